FILE: design/wchm_pkg.sv
// Package: shared types and constants for the windowed circular heading mean block.
package wchm_pkg;

    localparam int ATAN_LEN = 24;
    localparam logic [16:0] CORDIC_GAIN = 17'd39797;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_WL_UNSET = 2'd1,
        ST_TR_UNSET = 2'd2
    } t_status;

    // Payload layouts, field order as in the top-level header
    typedef struct packed {
        logic [15:0] heading;
        logic [31:0] timestamp;
        logic [15:0] speed;
    } t_nav_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] mean_heading;
        logic [22:0] peak_width;
        logic [6:0]  window_count;
        logic        dropped;
    } t_mean_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_STALE,
        S_DROP,
        S_SC_RD,
        S_SC_PRE,
        S_SC_IT,
        S_SC_ACC,
        S_AT_PRE,
        S_AT_IT,
        S_PEAK,
        S_DONE
    } t_state;

    typedef enum logic {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_TURN_RANGE    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic start;
        logic vect;
    } t_cordic_ctl;

    function automatic logic [31:0] atan_val(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2F9;
                5'd15: v = 32'h0000517C;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A2F;
                5'd19: v = 32'h00000517;
                5'd20: v = 32'h0000028B;
                5'd21: v = 32'h00000145;
                5'd22: v = 32'h000000A2;
                5'd23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: design/wchm_if.sv
// Interface: valid/ready channel carrying one item of a generic payload type.
interface wchm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/wchm_cordic.sv
// Module: shared CORDIC unit, one micro-rotation per cycle, rotation or vectoring mode.
module wchm_cordic
    import wchm_pkg::*;
#(
    parameter int ITER = 16,
    parameter int XW   = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cordic_ctl           i_ctl,
    input  logic signed [XW-1:0]  i_x,
    input  logic signed [XW-1:0]  i_y,
    input  logic signed [33:0]    i_z,
    output logic                  o_busy,
    output logic signed [XW-1:0]  o_x,
    output logic signed [XW-1:0]  o_y,
    output logic signed [33:0]    o_z
);
    logic signed [XW-1:0] r_x, r_y;
    logic signed [33:0]   r_z;
    logic [4:0]           r_i;
    logic                 r_busy, r_vect;
    logic                 dir;
    logic signed [XW-1:0] xs, ys;
    logic signed [33:0]   at;

    always_comb begin
        xs  = r_x >>> r_i;
        ys  = r_y >>> r_i;
        at  = $signed({2'b00, atan_val(r_i)});
        dir = r_vect ? (r_y >= 0) : (r_z >= 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
            r_vect <= i_ctl.vect;
            r_x    <= i_x;
            r_y    <= i_y;
            r_z    <= i_z;
        end else if (r_busy) begin
            if (r_vect ^ dir) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
            end
            r_z <= (r_vect ^ dir) ? r_z - at : r_z + at;
            if (r_i == 5'(ITER - 1)) r_busy <= 1'b0;
            r_i <= r_i + 5'd1;
        end
    end

    assign o_busy = r_busy;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
endmodule

FILE: design/windowed_circular_heading_mean_top.sv
// Top level: time-windowed circular mean of headings with peak width.
//
//  channel  dir  payload
//  in_ch    in   heading[15:0], timestamp[31:0], speed[15:0]
//  out_ch   out  status[1:0], mean_heading[15:0], peak_width[22:0],
//                window_count[6:0], dropped
//  cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data[22:0]
//
// From acceptance to result valid, every window entry (new item included) is
// checked for age through the single store read port, then the shared CORDIC
// unit runs once per kept entry and once more for the mean angle; both sums zero
// skips that last run. An item with an unset register goes straight to its result.
// Reset clears the window pointers and sets both registers unset; the stores
// need no clearing. in_ch is not ready while an item is at work or its result
// waits on out_ch.
module windowed_circular_heading_mean_top
    import wchm_pkg::*;
#(
    parameter int WINDOW_DEPTH      = 64,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [22:0] i_cfg_data,
    wchm_if.sink        in_ch,
    wchm_if.source      out_ch
);
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int XW = 20 + AW + 8;

    t_state r_state, n_state;

    logic [15:0] r_hstore [WINDOW_DEPTH];
    logic [31:0] r_tstore [WINDOW_DEPTH];
    logic [15:0] r_hrd;
    logic [31:0] r_trd;

    logic [AW-1:0] r_old, r_k;
    logic [CW-1:0] r_cnt, r_stale, r_idx;
    logic [22:0]   r_wl;
    logic [16:0]   r_tr;
    logic [15:0]   r_hd, r_sp;
    logic [31:0]   r_ts;
    logic          r_drop, r_ovalid;
    t_status       r_status;
    logic signed [XW-1:0] r_cs, r_ss;
    logic          r_flip;
    logic [33:0]   r_prod;
    logic [15:0]   r_mean;
    logic [22:0]   r_peak;

    t_cordic_ctl          c_ctl;
    logic signed [XW-1:0] c_xi, c_yi, c_xo, c_yo;
    logic signed [33:0]   c_zi, c_zo;
    logic                 c_busy;

    wchm_cordic #(.ITER(CORDIC_ITERATIONS), .XW(XW)) u_cordic (
        .i_clk, .i_rst_n, .i_ctl(c_ctl), .i_x(c_xi), .i_y(c_yi), .i_z(c_zi),
        .o_busy(c_busy), .o_x(c_xo), .o_y(c_yo), .o_z(c_zo)
    );

    logic [AW-1:0] rd_addr;
    logic [AW:0]   sum_w;
    logic [AW-1:0] wr_slot;
    logic signed [33:0] age;
    logic signed [33:0] z0;
    logic [31:0] ang;
    logic [33:0] pk;
    logic [50:0] pk_mul;
    logic [25:0] pk_q;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
        logic [AW:0] d;
        begin
            d = AW'(WINDOW_DEPTH) == 0 ? v : v;
            if (v >= (AW+1)'(WINDOW_DEPTH)) d = v - (AW+1)'(WINDOW_DEPTH);
            return d[AW-1:0];
        end
    endfunction

    assign sum_w   = {1'b0, r_old} + {1'b0, r_k};
    assign rd_addr = wrap(sum_w);
    assign age     = $signed({2'b0, r_ts}) - $signed({2'b0, r_trd});
    assign ang     = {r_hrd, 16'h0};
    assign pk      = r_prod + 34'd192;
    // divide by 384: drop 7 bits, then times ceil(2^25/3), exact below 2^25
    assign pk_mul  = 51'(pk[33:7]) * 51'(24'hAAAAAB);
    assign pk_q    = pk_mul[50:25];

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD && r_idx == '0) begin
            r_hstore[wr_slot] <= r_hd;
            r_tstore[wr_slot] <= r_ts;
        end
        r_hrd <= r_hstore[rd_addr];
        r_trd <= r_tstore[rd_addr];
    end

    assign wr_slot = wrap({1'b0, r_old} + (AW+1)'(r_cnt));

    // CORDIC setup: rotation angle pre-turned past +-90 degrees, or vectoring sums
    always_comb begin
        c_ctl = '0;
        c_xi  = '0;
        c_yi  = '0;
        z0    = $signed({{2{ang[31]}}, ang});
        c_zi  = z0;
        if (r_state == S_SC_PRE) begin
            c_ctl.start = 1'b1;
            c_xi = XW'(CORDIC_GAIN);
            if (z0 > 34'sh40000000)       c_zi = z0 - 34'sh80000000;
            else if (z0 < -34'sh40000000) c_zi = z0 + 34'sh80000000;
        end else if (r_state == S_AT_PRE && !(r_cs == 0 && r_ss == 0)) begin
            c_ctl.start = 1'b1;
            c_ctl.vect  = 1'b1;
            c_xi = r_cs[XW-1] ? -r_cs : r_cs;
            c_yi = r_cs[XW-1] ? -r_ss : r_ss;
            c_zi = r_cs[XW-1] ? 34'sh80000000 : '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_ch.valid && in_ch.ready)
                          n_state = (r_wl[22] || r_tr[16]) ? S_DONE : S_RD;
            S_RD:     n_state = S_STALE;
            S_STALE:  if (r_k == AW'(r_cnt - CW'(1))) n_state = S_DROP;
            S_DROP:   n_state = (r_cnt == '0) ? S_AT_PRE : S_SC_RD;
            S_SC_RD:  n_state = S_SC_PRE;
            S_SC_PRE: n_state = S_SC_IT;
            S_SC_IT:  if (!c_busy) n_state = S_SC_ACC;
            S_SC_ACC: n_state = (r_idx == r_cnt - CW'(1)) ? S_AT_PRE : S_SC_RD;
            S_AT_PRE: n_state = (r_cs == 0 && r_ss == 0) ? S_PEAK : S_AT_IT;
            S_AT_IT:  if (!c_busy) n_state = S_PEAK;
            S_PEAK:   n_state = S_DONE;
            S_DONE:   if (!r_ovalid) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old    <= '0;
            r_cnt    <= '0;
            r_wl     <= '1;
            r_tr     <= '1;
            r_ovalid <= 1'b0;
            r_status <= ST_OK;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WINDOW_LENGTH) r_wl <= i_cfg_data;
                else                                r_tr <= i_cfg_data[16:0];
            end
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (in_ch.valid && in_ch.ready) begin
                    r_hd <= in_ch.data.heading;
                    r_ts <= in_ch.data.timestamp;
                    r_sp <= in_ch.data.speed;
                    r_drop <= 1'b0;
                    r_mean <= '0;
                    r_peak <= '0;
                    r_idx <= '0;
                    r_status <= r_wl[22] ? ST_WL_UNSET :
                                r_tr[16] ? ST_TR_UNSET : ST_OK;
                    if (!r_wl[22] && !r_tr[16] && r_cnt == CW'(WINDOW_DEPTH)) begin
                        r_old  <= wrap({1'b0, r_old} + (AW+1)'(1));
                        r_cnt  <= CW'(WINDOW_DEPTH - 1);
                        r_drop <= 1'b1;
                    end
                end
                S_RD: begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_k     <= '0;
                    r_stale <= '0;
                    r_idx   <= CW'(1);
                end
                S_STALE: begin
                    // read data is registered, so the data seen here belongs to slot k-1
                    if (r_idx == CW'(2) || r_idx > CW'(1)) begin
                        if (age > $signed({11'b0, r_wl})) r_stale <= r_stale + CW'(1);
                    end
                    r_k   <= r_k + AW'(1);
                    r_idx <= r_idx + CW'(1);
                end
                S_DROP: begin
                    if (age > $signed({11'b0, r_wl})) begin
                        r_old <= wrap({1'b0, r_old} + (AW+1)'(r_stale + CW'(1)));
                        r_cnt <= r_cnt - r_stale - CW'(1);
                    end else begin
                        r_old <= wrap({1'b0, r_old} + (AW+1)'(r_stale));
                        r_cnt <= r_cnt - r_stale;
                    end
                    r_k   <= '0;
                    r_idx <= '0;
                    r_cs  <= '0;
                    r_ss  <= '0;
                end
                S_SC_RD: ;
                S_SC_PRE: r_flip <= (z0 > 34'sh40000000) || (z0 < -34'sh40000000);
                S_SC_IT: ;
                S_SC_ACC: begin
                    r_cs  <= r_flip ? r_cs - c_xo : r_cs + c_xo;
                    r_ss  <= r_flip ? r_ss - c_yo : r_ss + c_yo;
                    r_k   <= r_k + AW'(1);
                    r_idx <= r_idx + CW'(1);
                end
                S_AT_PRE: r_prod <= 34'(r_tr[15:0] * r_sp) + (r_tr[16] ? 34'd0 : 34'd0);
                S_AT_IT: ;
                S_PEAK: begin
                    if (!(r_cs == 0 && r_ss == 0)) r_mean <= 16'(c_zo[31:0] + 32'h8000 >> 16);
                    r_peak <= (pk_q > 26'h7FFFFF) ? 23'h7FFFFF : pk_q[22:0];
                end
                S_DONE: if (!r_ovalid) r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign in_ch.ready             = (r_state == S_IDLE) && !r_ovalid;
    assign out_ch.valid            = r_ovalid;
    assign out_ch.data.status      = r_status;
    assign out_ch.data.mean_heading = r_mean;
    assign out_ch.data.peak_width  = r_peak;
    assign out_ch.data.window_count = 7'(r_cnt);
    assign out_ch.data.dropped     = r_drop;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(WINDOW_DEPTH)) else $error("count overflow");
    a_unset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && r_status != ST_OK |-> r_mean == '0 && r_peak == '0)
        else $error("unset status with payload");
endmodule
